/* rtl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the camera frame assembler
// Holds the opcodes, the trailer marker bytes, the capture length reset value
// and the item and result records passed between the top level and the
// frame controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_RETURN = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Trailer: four marker bytes and one final byte
    localparam int unsigned TRAILER_LEN = 5;
    localparam logic [7:0]  MARKER_0    = 8'hAA;
    localparam logic [7:0]  MARKER_1    = 8'h11;
    localparam logic [7:0]  MARKER_2    = 8'hCC;
    localparam logic [7:0]  MARKER_3    = 8'hEE;

    localparam logic [23:0] CAPTURE_LENGTH_RESET = 24'd1310725;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic        chunk_first;
        logic        chunk_last;
        logic [23:0] chunk_length;
    } t_item;

    typedef struct packed {
        logic        write_enable;
        logic [1:0]  write_slot;
        logic [23:0] write_offset;
        logic [7:0]  write_data;
        logic        frame_done;
        logic [1:0]  done_slot;
        logic [31:0] dropped_count;
        logic [2:0]  free_slots;
    } t_result;

endpackage

`default_nettype wire

/* rtl/camera_frame_assembler.sv */
// ----------------------------------------------------------------------------
// camera_frame_assembler: frame assembly from chunked byte transfers
// Registers each input item, runs it through the frame controller and
// holds the result in an output register until the consumer takes it.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   input   | in        | i_valid / o_stall   | opcode, byte, chunk flags/len
//   output  | out       | o_valid / i_stall   | write, release, counters
//   config  | in        | i_cfg_wr_en         | capture length (24 bits)
//
// One item per clock sustained while i_stall is low; input register, then
// result register; the single-pass controller between them sets the rate.
// Reset is synchronous and takes effect at once; there is no clearing pass.
// A stalled result holds in the output register while the input register
// takes one more item; o_stall then rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_frame_assembler
    import cfa_pkg::*;
#(
    parameter int SLOTS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_wr_en,
    input  wire logic [23:0] i_cfg_wr_data,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_chunk_first,
    input  wire logic        i_chunk_last,
    input  wire logic [23:0] i_chunk_length,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_write_enable,
    output logic [1:0]       o_write_slot,
    output logic [23:0]      o_write_offset,
    output logic [7:0]       o_write_data,
    output logic             o_frame_done,
    output logic [1:0]       o_done_slot,
    output logic [31:0]      o_dropped_count,
    output logic [2:0]       o_free_slots
);

    logic [23:0] r_capture_length;
    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;
    t_result     step_result;
    logic        advance;
    logic        in_take;

    // Advance the registered item when the result register is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    // Capture length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_length <= CAPTURE_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_capture_length <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.opcode       <= i_opcode;
            r_item.data_byte    <= i_data_byte;
            r_item.chunk_first  <= i_chunk_first;
            r_item.chunk_last   <= i_chunk_last;
            r_item.chunk_length <= i_chunk_length;
        end
    end

    cfa_frame_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (advance),
        .i_item           (r_item),
        .i_capture_length (r_capture_length),
        .o_result         (step_result)
    );

    // Result register: load on advance, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_enable  = r_result.write_enable;
    assign o_write_slot    = r_result.write_slot;
    assign o_write_offset  = r_result.write_offset;
    assign o_write_data    = r_result.write_data;
    assign o_frame_done    = r_result.frame_done;
    assign o_done_slot     = r_result.done_slot;
    assign o_dropped_count = r_result.dropped_count;
    assign o_free_slots    = r_result.free_slots;

endmodule

`default_nettype wire

/* rtl/cfa_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// cfa_frame_ctrl: frame state and per-item decision logic
// Keeps the byte count, slot ring, free slot count, drop counter and the
// last five bytes. Computes the result of one item in a single pass and
// commits the new state on the cycle the item advances.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_frame_ctrl
    import cfa_pkg::*;
#(
    parameter int SLOTS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    input  wire logic [23:0] i_capture_length,
    output t_result          o_result
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);

    // State
    logic [23:0]   r_rcvd,   n_rcvd;
    logic [SW-1:0] r_slot,   n_slot;
    logic [FW-1:0] r_free,   n_free;
    logic [31:0]   r_drop,   n_drop;
    logic          r_accept, n_accept;
    logic [7:0]    r_recent [TRAILER_LEN];
    logic [7:0]    n_recent [TRAILER_LEN];

    // Intermediate values
    logic [24:0]   fit_sum;
    logic          chunk_ok;
    logic          accept_eff;
    logic          drop_first;
    logic [23:0]   rcvd_base;
    logic          do_write;
    logic [23:0]   rcvd_after;
    logic          marker_hit;
    logic          frame_rel;
    logic [SW+1:0] slot_ext;
    logic [SW+1:0] done_ext;
    logic [FW+2:0] free_ext;

    always_comb begin
        n_rcvd     = r_rcvd;
        n_slot     = r_slot;
        n_free     = r_free;
        n_drop     = r_drop;
        n_accept   = r_accept;
        n_recent   = r_recent;
        fit_sum    = {1'b0, r_rcvd} + {1'b0, i_item.chunk_length};
        chunk_ok   = (r_free != '0) && (fit_sum <= {1'b0, i_capture_length});
        accept_eff = 1'b0;
        drop_first = 1'b0;
        rcvd_base  = r_rcvd;
        do_write   = 1'b0;
        rcvd_after = r_rcvd;
        marker_hit = 1'b0;
        frame_rel  = 1'b0;

        case (i_item.opcode)
            OP_DATA: begin
                // Admit or reject the chunk at its first byte
                accept_eff = i_item.chunk_first ? chunk_ok : r_accept;
                drop_first = i_item.chunk_first && !chunk_ok;
                rcvd_base  = drop_first ? 24'd0 : r_rcvd;

                // Store the byte while the frame has room
                do_write   = accept_eff && (rcvd_base < i_capture_length);
                rcvd_after = do_write ? rcvd_base + 24'd1 : rcvd_base;
                if (do_write) begin
                    for (int k = TRAILER_LEN - 1; k > 0; k--) begin
                        n_recent[k] = r_recent[k-1];
                    end
                    n_recent[0] = i_item.data_byte;
                end
                n_rcvd   = rcvd_after;
                n_accept = accept_eff;
                if (drop_first) begin
                    n_drop = r_drop + 32'd1;
                end

                // Check the trailer at the chunk end
                marker_hit = (n_recent[4] == MARKER_0) && (n_recent[3] == MARKER_1) &&
                             (n_recent[2] == MARKER_2) && (n_recent[1] == MARKER_3);
                if (i_item.chunk_last) begin
                    if (accept_eff && rcvd_after >= 24'(TRAILER_LEN) && marker_hit) begin
                        if (rcvd_after == i_capture_length) begin
                            frame_rel = 1'b1;
                            if (r_free != '0) begin
                                n_free = r_free - FW'(1);
                            end
                            n_slot = (r_slot == SW'(SLOTS - 1)) ? '0 : r_slot + SW'(1);
                            n_rcvd = 24'd0;
                        end else if (rcvd_after == 24'(TRAILER_LEN)) begin
                            n_rcvd = 24'd0;
                        end else begin
                            n_drop = r_drop + 32'd1;
                            n_rcvd = 24'd0;
                        end
                    end
                    n_accept = 1'b0;
                end
            end
            OP_RETURN: begin
                // Return a slot, saturating at the ring size
                if (r_free < FW'(SLOTS)) begin
                    n_free = r_free + FW'(1);
                end
            end
            OP_CLEAR: begin
                n_drop = 32'd0;
            end
            default: begin
            end
        endcase

        // Assemble the result, masked to field widths
        slot_ext = {2'b00, (do_write  ? r_slot : SW'(0))};
        done_ext = {2'b00, (frame_rel ? r_slot : SW'(0))};
        free_ext = {3'b000, n_free};
        o_result.write_enable  = do_write;
        o_result.write_slot    = slot_ext[1:0];
        o_result.write_offset  = do_write ? rcvd_base : 24'd0;
        o_result.write_data    = do_write ? i_item.data_byte : 8'd0;
        o_result.frame_done    = frame_rel;
        o_result.done_slot     = done_ext[1:0];
        o_result.dropped_count = n_drop;
        o_result.free_slots    = free_ext[2:0];
    end

    // Commit state when the item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcvd   <= 24'd0;
            r_slot   <= '0;
            r_free   <= FW'(SLOTS);
            r_drop   <= 32'd0;
            r_accept <= 1'b0;
            for (int k = 0; k < TRAILER_LEN; k++) begin
                r_recent[k] <= 8'd0;
            end
        end else if (i_fire) begin
            r_rcvd   <= n_rcvd;
            r_slot   <= n_slot;
            r_free   <= n_free;
            r_drop   <= n_drop;
            r_accept <= n_accept;
            r_recent <= n_recent;
        end
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(SLOTS))
        else $error("free slot count above ring size");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(SLOTS - 1))
        else $error("current slot outside ring");

    a_release_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.frame_done |=> r_drop == $past(r_drop))
        else $error("frame released and dropped in one step");

    a_release_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.frame_done |=> r_rcvd == 24'd0 && !r_accept)
        else $error("byte count not cleared after release");
`endif

endmodule

`default_nettype wire
